/* rtl/assert_macros.svh */
// Assertion helper macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion clocked on the rising edge, disabled in reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication check: when the antecedent holds, the consequent must hold.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* rtl/md5h_pkg.sv */
// ----------------------------------------------------------------------------
// MD5 hasher package
// Item types and round constant tables for the streaming MD5 hasher.
// ----------------------------------------------------------------------------
package md5h_pkg;

  localparam logic REQ_ABSORB = 1'b0;
  localparam logic REQ_FINISH = 1'b1;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam int unsigned LEN_POS = 56;

  typedef struct packed {
    logic       req_type;
    logic [7:0] data_byte;
  } md5h_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic [63:0] bit_length;
    logic        last_word;
  } md5h_out_t;

  // Queue entry passed from the front part to the back part.
  typedef struct packed {
    logic       fin;
    logic [7:0] data;
  } md5h_cmd_t;

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;  6'd2: k = 32'h242070db;
      6'd3: k = 32'hc1bdceee;  6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;  6'd8: k = 32'h698098d8;
      6'd9: k = 32'h8b44f7af;  6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] rot_amt(input logic [5:0] i);
    logic [4:0] r;
    case ({i[5:4], i[1:0]})
      4'd0: r = 5'd7;   4'd1: r = 5'd12;  4'd2: r = 5'd17;  4'd3: r = 5'd22;
      4'd4: r = 5'd5;   4'd5: r = 5'd9;   4'd6: r = 5'd14;  4'd7: r = 5'd20;
      4'd8: r = 5'd4;   4'd9: r = 5'd11;  4'd10: r = 5'd16; 4'd11: r = 5'd23;
      4'd12: r = 5'd6;  4'd13: r = 5'd10; 4'd14: r = 5'd15; default: r = 5'd21;
    endcase
    return r;
  endfunction

  // Message word index used by round i.
  function automatic logic [3:0] msg_idx(input logic [5:0] i);
    logic [3:0] g;
    case (i[5:4])
      2'd0: g = i[3:0];
      2'd1: g = 4'(5 * i[3:0] + 1);
      2'd2: g = 4'(3 * i[3:0] + 5);
      default: g = 4'(7 * i[3:0]);
    endcase
    return g;
  endfunction

endpackage

/* rtl/md5h_front.sv */
// ----------------------------------------------------------------------------
// MD5 hasher front end
// Accepts items and writes them into a small command queue.
// ----------------------------------------------------------------------------
module md5h_front import md5h_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  md5h_in_t  in_data_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output md5h_cmd_t cmd_o,
  output logic      cmd_valid_o,
  input  logic      cmd_ready_i
);

  localparam int unsigned Depth = 4;

  md5h_cmd_t  mem_q [Depth];
  logic [1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [2:0] cnt_q, cnt_d;
  logic       push, pop;

  assign in_ready_o  = (cnt_q != 3'(Depth));
  assign cmd_valid_o = (cnt_q != 3'd0);
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = mem_q[rptr_q];

  always_comb begin
    wptr_d = push ? wptr_q + 2'd1 : wptr_q;
    rptr_d = pop ? rptr_q + 2'd1 : rptr_q;
    cnt_d  = cnt_q + 3'(push) - 3'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= '{fin: in_data_i.req_type, data: in_data_i.data_byte};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

`include "assert_macros.svh"
  `ASSERT_CLK(a_cnt_range, cnt_q <= 3'(Depth), "queue count overflow")
  `ASSERT_IMPL(a_no_ovf, cnt_q == 3'(Depth), !push, "push into full queue")
  `ASSERT_IMPL(a_cnt_step, push && !pop, cnt_d == cnt_q + 3'd1, "count step wrong")

endmodule

/* rtl/md5h_core.sv */
// ----------------------------------------------------------------------------
// MD5 hasher back end
// Block buffer, padding, 64-round compression and digest output.
// ----------------------------------------------------------------------------
module md5h_core import md5h_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  md5h_cmd_t cmd_i,
  input  logic      cmd_valid_i,
  output logic      cmd_ready_o,
  output md5h_out_t out_data_o,
  output logic      out_valid_o,
  input  logic      out_ready_i
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PAD  = 3'd1;
  localparam logic [2:0] ST_LOAD = 3'd2;
  localparam logic [2:0] ST_RND  = 3'd3;
  localparam logic [2:0] ST_ADD  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0]  st_q, st_d;
  logic [31:0] buf_q [16];
  logic [5:0]  fill_q, fill_d;
  logic [63:0] cnt_q, cnt_d;
  logic [31:0] ca_q, cb_q, cc_q, cd_q;
  logic [31:0] a_q, b_q, c_q, d_q;
  logic [5:0]  rnd_q, rnd_d;
  logic [5:0]  pad_q, pad_d;
  logic        fin_q, fin_d;
  logic        two_q, two_d;
  logic [1:0]  oidx_q, oidx_d;
  logic [31:0] mword_q;
  logic [3:0]  midx;
  logic [31:0] f, t, rot, kc_q;
  logic [5:0]  nidx;
  logic        wr_en;
  logic [5:0]  wr_addr;
  logic [7:0]  wr_byte;

  assign cmd_ready_o = (st_q == ST_IDLE);

  // The message word for round r is fetched in the cycle before that round.
  assign nidx = (st_q == ST_LOAD) ? 6'd0 : rnd_q + 6'd1;
  assign midx = msg_idx(nidx);

  always_ff @(posedge clk_i) begin
    mword_q <= buf_q[midx];
    kc_q <= round_k(nidx);
    if (wr_en) begin
      buf_q[wr_addr[5:2]][{wr_addr[1:0], 3'd0} +: 8] <= wr_byte;
    end
  end

  always_comb begin
    case (rnd_q[5:4])
      2'd0: f = (b_q & c_q) | (~b_q & d_q);
      2'd1: f = (d_q & b_q) | (~d_q & c_q);
      2'd2: f = b_q ^ c_q ^ d_q;
      default: f = c_q ^ (b_q | ~d_q);
    endcase
    t   = f + a_q + mword_q + kc_q;
    rot = (t << rot_amt(rnd_q)) | (t >> (6'd32 - {1'b0, rot_amt(rnd_q)}));
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = fill_q;
    wr_byte = cmd_i.data;
    if (st_q == ST_IDLE && cmd_valid_i) begin
      wr_en   = 1'b1;
      wr_byte = cmd_i.fin ? PAD_BYTE : cmd_i.data;
    end else if (st_q == ST_PAD) begin
      wr_en   = 1'b1;
      wr_addr = pad_q;
      wr_byte = (!two_q && pad_q >= 6'(LEN_POS)) ? cnt_q[{pad_q[2:0], 3'd0} +: 8] : 8'd0;
    end
  end

  always_comb begin
    st_d   = st_q;
    fill_d = fill_q;
    cnt_d  = cnt_q;
    rnd_d  = rnd_q;
    pad_d  = pad_q;
    fin_d  = fin_q;
    two_d  = two_q;
    oidx_d = oidx_q;
    case (st_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          if (cmd_i.fin) begin
            fin_d = 1'b1;
            two_d = (fill_q >= 6'(LEN_POS));
            pad_d = fill_q + 6'd1;
            st_d  = (fill_q == 6'd63) ? ((fill_q >= 6'(LEN_POS)) ? ST_LOAD : ST_PAD)
                                      : ST_PAD;
          end else begin
            cnt_d  = cnt_q + 64'd8;
            fill_d = fill_q + 6'd1;
            fin_d  = 1'b0;
            if (fill_q == 6'd63) st_d = ST_LOAD;
          end
        end
      end
      ST_PAD: begin
        pad_d = pad_q + 6'd1;
        if (pad_q == 6'd63) st_d = ST_LOAD;
      end
      ST_LOAD: begin
        rnd_d = 6'd0;
        st_d  = ST_RND;
      end
      ST_RND: begin
        rnd_d = rnd_q + 6'd1;
        if (rnd_q == 6'd63) st_d = ST_ADD;
      end
      ST_ADD: begin
        if (!fin_q) begin
          st_d = ST_IDLE;
        end else if (two_q) begin
          two_d = 1'b0;
          pad_d = 6'd0;
          st_d  = ST_PAD;
        end else begin
          oidx_d = 2'd0;
          st_d   = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_ready_i) begin
          oidx_d = oidx_q + 2'd1;
          if (oidx_q == 2'd3) begin
            st_d   = ST_IDLE;
            fin_d  = 1'b0;
            fill_d = 6'd0;
            cnt_d  = '0;
          end
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_IDLE;
      fill_q <= '0;
      cnt_q  <= '0;
      rnd_q  <= '0;
      pad_q  <= '0;
      fin_q  <= 1'b0;
      two_q  <= 1'b0;
      oidx_q <= '0;
      ca_q   <= IV_A;
      cb_q   <= IV_B;
      cc_q   <= IV_C;
      cd_q   <= IV_D;
    end else begin
      st_q   <= st_d;
      fill_q <= fill_d;
      cnt_q  <= cnt_d;
      rnd_q  <= rnd_d;
      pad_q  <= pad_d;
      fin_q  <= fin_d;
      two_q  <= two_d;
      oidx_q <= oidx_d;
      if (st_q == ST_ADD) begin
        ca_q <= ca_q + a_q;
        cb_q <= cb_q + b_q;
        cc_q <= cc_q + c_q;
        cd_q <= cd_q + d_q;
      end else if (st_q == ST_OUT && out_ready_i && oidx_q == 2'd3) begin
        ca_q <= IV_A;
        cb_q <= IV_B;
        cc_q <= IV_C;
        cd_q <= IV_D;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == ST_LOAD) begin
      a_q <= ca_q;
      b_q <= cb_q;
      c_q <= cc_q;
      d_q <= cd_q;
    end else if (st_q == ST_RND) begin
      a_q <= d_q;
      d_q <= c_q;
      c_q <= b_q;
      b_q <= b_q + rot;
    end
  end

  assign out_valid_o = (st_q == ST_OUT);
  always_comb begin
    out_data_o.word_index = oidx_q;
    out_data_o.bit_length = cnt_q;
    out_data_o.last_word  = (oidx_q == 2'd3);
    case (oidx_q)
      2'd0: out_data_o.digest_word = ca_q;
      2'd1: out_data_o.digest_word = cb_q;
      2'd2: out_data_o.digest_word = cc_q;
      default: out_data_o.digest_word = cd_q;
    endcase
  end

`include "assert_macros.svh"
  `ASSERT_IMPL(a_rnd_done, st_q == ST_ADD, $past(rnd_q) == 6'd63, "round count wrong")
  `ASSERT_IMPL(a_no_take, st_q != ST_IDLE, !cmd_ready_o, "took item while busy")
  `ASSERT_IMPL(a_out_fin, out_valid_o, fin_q && !two_q, "digest out of finish")

endmodule

/* rtl/md5_stream_hasher_top.sv */
// ----------------------------------------------------------------------------
// Streaming MD5 hasher, top level
// Item input channel and digest output channel with valid and ready.
// ----------------------------------------------------------------------------
// Each input item is either one message byte or a finish request. Byte items
// go through a four-entry queue into the hashing core, which writes them into
// a 64-byte block buffer. The 64th byte of a block starts the compression: a
// load step, the rounds on one shared round unit, and an add into the
// chaining words. A finish item pads the buffer one byte per cycle, runs one
// or two final compressions, and then presents four result items, words A,
// B, C and D with the bit length, one per accepted output cycle. With an
// empty queue, how soon the first digest word appears after the finish item
// is accepted depends on the fill of the last block.
// The queue keeps taking items while the core is busy, up to four.
// If the receiver stalls, the core holds the current digest word and stops
// taking queue entries; input then backs up once the queue is full.
// Reset clears the queue, sets the chaining words to the initial vector and
// zeroes the fill count and the bit count; no clearing pass is needed.
module md5_stream_hasher_top import md5h_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  md5h_in_t  in_data_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output md5h_out_t out_data_o,
  output logic      out_valid_o,
  input  logic      out_ready_i
);

  md5h_cmd_t cmd;
  logic      cmd_valid, cmd_ready;

  md5h_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd),
    .cmd_valid_o(cmd_valid),
    .cmd_ready_i(cmd_ready)
  );

  md5h_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cmd_valid_i(cmd_valid),
    .cmd_ready_o(cmd_ready),
    .out_data_o (out_data_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i)
  );

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// Streaming MD5 hasher testbench
// Drives byte and finish items with or without random gaps, predicts the four digest
// words of every message with an in-bench MD5 model, and checks each result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import md5h_pkg::*;

  localparam int unsigned IdleLimit = 20000;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  md5h_in_t  in_data_i = '0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  md5h_out_t out_data_o;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;

  logic [31:0] chain_q [4];
  logic [7:0]  block_q [64];
  logic [5:0]  fill_q;
  logic [63:0] nbits_q;
  md5h_out_t   digest_q [$];
  int          err_cnt = 0;
  int          idle_cnt = 0;
  bit          hold_off = 1'b0;

  md5_stream_hasher_top dut (.*);

  always #5 clk_i = ~clk_i;

  function automatic logic [31:0] rotl(logic [31:0] x, int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic void md5_compress();
    logic [31:0] a, b, c, d, f, t, w;
    int g;
    logic [31:0] kt [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee, 32'hf57c0faf, 32'h4787c62a,
      32'ha8304613, 32'hfd469501, 32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821, 32'hf61e2562, 32'hc040b340,
      32'h265e5a51, 32'he9b6c7aa, 32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed, 32'ha9e3e905, 32'hfcefa3f8,
      32'h676f02d9, 32'h8d2a4c8a, 32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70, 32'h289b7ec6, 32'heaa127fa,
      32'hd4ef3085, 32'h04881d05, 32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039, 32'h655b59c3, 32'h8f0ccc92,
      32'hffeff47d, 32'h85845dd1, 32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
    int ra [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
    a = chain_q[0]; b = chain_q[1]; c = chain_q[2]; d = chain_q[3];
    for (int i = 0; i < 64; i++) begin
      if (i < 16) begin
        f = (b & c) | (~b & d); g = i;
      end else if (i < 32) begin
        f = (d & b) | (~d & c); g = (5 * i + 1) % 16;
      end else if (i < 48) begin
        f = b ^ c ^ d; g = (3 * i + 5) % 16;
      end else begin
        f = c ^ (b | ~d); g = (7 * i) % 16;
      end
      w = {block_q[4*g+3], block_q[4*g+2], block_q[4*g+1], block_q[4*g]};
      t = f + a + w + kt[i];
      a = d; d = c; c = b;
      b = b + rotl(t, ra[(i / 16) * 4 + i % 4]);
    end
    chain_q[0] += a; chain_q[1] += b; chain_q[2] += c; chain_q[3] += d;
  endfunction

  function automatic void clear_state();
    chain_q = '{IV_A, IV_B, IV_C, IV_D};
    fill_q = '0;
    nbits_q = '0;
  endfunction

  function automatic void predict_item(md5h_in_t it);
    md5h_out_t r;
    int fill;
    fill = fill_q;
    if (it.req_type == REQ_ABSORB) begin
      block_q[fill] = it.data_byte;
      nbits_q += 64'd8;
      fill_q = fill_q + 6'd1;
      if (fill == 63) md5_compress();
      return;
    end
    block_q[fill] = PAD_BYTE;
    for (int i = fill + 1; i < 64; i++) block_q[i] = '0;
    if (fill >= LEN_POS) begin
      md5_compress();
      for (int i = 0; i < 64; i++) block_q[i] = '0;
    end
    for (int i = 0; i < 8; i++) block_q[LEN_POS + i] = nbits_q[8*i +: 8];
    md5_compress();
    for (int k = 0; k < 4; k++) begin
      r.digest_word = chain_q[k];
      r.word_index = 2'(k);
      r.bit_length = nbits_q;
      r.last_word = (k == 3);
      digest_q.push_back(r);
    end
    clear_state();
  endfunction

  task automatic send_item(logic kind, logic [7:0] val, bit gaps = 1'b1);
    md5h_in_t it;
    int gap;
    gap = gaps ? $urandom_range(0, 15) : 0;
    if (gaps && $urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    it.req_type = kind;
    it.data_byte = val;
    in_data_i <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    predict_item(it);
  endtask

  task automatic send_message(int len, bit gaps = 1'b1);
    for (int i = 0; i < len; i++) send_item(REQ_ABSORB, 8'($urandom), gaps);
    send_item(REQ_FINISH, 8'($urandom), gaps);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    send_item(REQ_FINISH, 8'hff);
    wait_drained();
    send_item(REQ_ABSORB, 8'h00);
    send_item(REQ_ABSORB, 8'hff);
    send_item(REQ_ABSORB, 8'h55);
    send_item(REQ_ABSORB, 8'haa);
    send_item(REQ_FINISH, 8'h00);
    send_item(REQ_ABSORB, 8'h61);
    send_item(REQ_FINISH, 8'h00);
    wait_drained();
  endtask

  task automatic test_block_edges();
    int lens [4] = '{55, 56, 63, 64};
    foreach (lens[i]) send_message(lens[i]);
    wait_drained();
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    send_message(3, 1'b0);
    send_message(10, 1'b0);
    hold_off = 1'b0;
    wait_drained();
  endtask

  task automatic test_random();
    int sent;
    int len;
    sent = 0;
    while (sent < 130) begin
      case ($urandom_range(0, 3))
        0: len = $urandom_range(0, 8);
        1: len = $urandom_range(50, 70);
        default: len = $urandom_range(0, 70);
      endcase
      send_message(len, $urandom_range(0, 3) != 0);
      sent += len + 1;
    end
    wait_drained();
  endtask

  // Receiver side: random stalls, plus a long hold-off on request.
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      if (hold_off) begin
        out_ready_i <= 1'b0;
        repeat (300) @(posedge clk_i);
      end
      stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 15);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin
    md5h_out_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (digest_q.size() == 0) begin
        $display("%0t: unexpected result, actual %h", $time, out_data_o);
        err_cnt++;
      end else begin
        exp_r = digest_q.pop_front();
        if (out_data_o.digest_word !== exp_r.digest_word) begin
          $display("%0t: digest_word expected %h actual %h", $time,
                   exp_r.digest_word, out_data_o.digest_word);
          err_cnt++;
        end
        if (out_data_o.word_index !== exp_r.word_index) begin
          $display("%0t: word_index expected %0d actual %0d", $time,
                   exp_r.word_index, out_data_o.word_index);
          err_cnt++;
        end
        if (out_data_o.bit_length !== exp_r.bit_length) begin
          $display("%0t: bit_length expected %0d actual %0d", $time,
                   exp_r.bit_length, out_data_o.bit_length);
          err_cnt++;
        end
        if (out_data_o.last_word !== exp_r.last_word) begin
          $display("%0t: last_word expected %b actual %b", $time,
                   exp_r.last_word, out_data_o.last_word);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cnt <= 0;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
    if (idle_cnt == IdleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    clear_state();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_block_edges();
    test_backpressure();
    test_random();
    repeat (200) @(posedge clk_i);
    if (err_cnt == 0 && digest_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
